FILE: rtl/core/hsrp_pkg.sv
// ----------------------------------------------------------------------------
// hsrp_pkg
// Shared constants, codes and types of the hard-sphere rejection placer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsrp_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int COORD_BITS = 16;

    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PER_W      = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = SQ_W + 2;
    localparam int WORD_W     = 3 * COORD_BITS;
    localparam int TGT_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIST_W;
    localparam int CELL_LAT   = 3;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd4;

    localparam logic [PER_W-1:0]  PERIOD_RST = PER_W'(1) << COORD_BITS;
    localparam logic [TGT_W-1:0]  TARGET_RST = TGT_W'(MAX_POINTS);
    localparam logic [DIST_W-1:0] DIST_MAX   = '1;

    typedef struct packed {
        logic [COORD_BITS-1:0] cand_x;
        logic [COORD_BITS-1:0] cand_y;
        logic [COORD_BITS-1:0] cand_z;
    } t_cand;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  point_index;
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] nearest_dist_sq;
    } t_res;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

`default_nettype wire

FILE: rtl/core/hsrp_cand_if.sv
// ----------------------------------------------------------------------------
// hsrp_cand_if
// Candidate request channel: valid, ready and one candidate point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hsrp_cand_if;
    import hsrp_pkg::*;

    logic  valid;
    logic  ready;
    t_cand data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hsrp_res_if.sv
// ----------------------------------------------------------------------------
// hsrp_res_if
// Result request channel: valid, ready and one placement result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hsrp_res_if;
    import hsrp_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hard_sphere_rejection_placer_unit.sv
// ----------------------------------------------------------------------------
// hard_sphere_rejection_placer_unit
// Dart-throwing placer: nearest-point search over the store, then accept,
// reject or report full.
// ----------------------------------------------------------------------------
// Usage:
//   i_cand carries one candidate request (x, y, z); o_res returns one result
//   request per candidate. Both are valid/ready channels. Registers are
//   written through i_cfg_we / i_cfg_idx / i_cfg_data while the unit is idle;
//   the unit does not enforce this, the user must. Accepted points go into a
//   4096-entry store RAM that is read one entry per cycle during the search;
//   the distance is formed by a chain of three axis cells (x, y, z), each
//   registering the wrapped difference, its square and the sum, followed by
//   a running minimum; an empty store skips the search. The next candidate
//   is taken once the result is loaded into the output register, so searches
//   do not overlap. Reset empties the store (count to zero), loads register
//   defaults and drops any pending result. A stalled receiver holds the
//   result in the output register; one more candidate can then be searched,
//   but its result waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hard_sphere_rejection_placer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hsrp_cand_if.sink                         i_cand,
    hsrp_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [hsrp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hsrp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hsrp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state;
    logic [DIST_W-1:0] r_min_dist;
    logic [PER_W-1:0]  r_period_x;
    logic [PER_W-1:0]  r_period_y;
    logic              r_periodic;
    logic [TGT_W-1:0]  r_target;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rd_cnt;
    t_tag              r_rd_tag;
    logic [WORD_W-1:0] r_cword;

    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic              r_found;

    logic              r_out_valid;
    t_res              r_out;

    logic [COORD_BITS-1:0] r_ydly [CELL_LAT];
    logic [COORD_BITS-1:0] r_zdly [2*CELL_LAT];

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_full;
    logic              w_reject;
    logic              w_store;
    logic              w_last_rd;
    logic [WORD_W-1:0] w_rdata;
    t_tag              w_tag0;
    t_tag              w_tag1;
    t_tag              w_tag;
    t_tag              w_tag2;
    logic [DIST_W-1:0] w_sum0;
    logic [DIST_W-1:0] w_sum1;
    logic [DIST_W-1:0] w_sum2;

    assign i_cand.ready = (r_state == S_IDLE);
    assign w_in_acc     = i_cand.valid && i_cand.ready;
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_last_rd    = (r_rd_cnt == (r_count - CNT_W'(1)));

    assign w_full   = (32'(r_count) >= 32'(r_target)) || (32'(r_count) >= 32'(MAX_POINTS));
    assign w_reject = r_found && (r_best <= r_min_dist);
    assign w_store  = (r_state == S_DONE) && w_out_free && !w_full && !w_reject;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= '0;
            r_period_x <= PERIOD_RST;
            r_period_y <= PERIOD_RST;
            r_periodic <= 1'b1;
            r_target   <= TARGET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_DIST: r_min_dist <= i_cfg_data[DIST_W-1:0];
                CFG_PERIOD_X: r_period_x <= i_cfg_data[PER_W-1:0];
                CFG_PERIOD_Y: r_period_y <= i_cfg_data[PER_W-1:0];
                CFG_PERIODIC: r_periodic <= i_cfg_data[0];
                CFG_TARGET:   r_target   <= i_cfg_data[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        r_rd_tag.last <= w_last_rd;
        r_rd_tag.idx  <= r_rd_cnt[IDX_W-1:0];
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_rd_tag.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_tag.valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= (r_count == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_tag.valid <= 1'b1;
                    if (w_last_rd) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_tag2.valid && w_tag2.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // read side, running minimum, result register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cword    <= {i_cand.data.cand_z, i_cand.data.cand_y, i_cand.data.cand_x};
            r_rd_cnt   <= '0;
            r_best     <= DIST_MAX;
            r_best_idx <= '0;
            r_found    <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (w_tag2.valid && (!r_found || (w_sum2 < r_best))) begin
                r_best     <= w_sum2;
                r_best_idx <= w_tag2.idx;
                r_found    <= 1'b1;
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.status          <= w_full ? ST_FULL : (w_reject ? ST_REJECT : ST_ACCEPT);
            r_out.point_index     <= w_store ? r_count[IDX_W-1:0] : '0;
            r_out.nearest_index   <= r_best_idx;
            r_out.nearest_dist_sq <= r_best;
        end
    end

    hsrp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_cword),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // skew y and z so each arrives with the running sum
    always_ff @(posedge i_clk) begin
        r_ydly[0] <= w_rdata[2*COORD_BITS-1:COORD_BITS];
        r_zdly[0] <= w_rdata[3*COORD_BITS-1:2*COORD_BITS];
        for (int k = 1; k < CELL_LAT; k++) begin
            r_ydly[k] <= r_ydly[k-1];
        end
        for (int k = 1; k < 2*CELL_LAT; k++) begin
            r_zdly[k] <= r_zdly[k-1];
        end
    end

    assign w_tag0 = r_rd_tag;

    hsrp_cell u_cell_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_in_acc),
        .i_cand   (i_cand.data.cand_x),
        .i_period (r_period_x),
        .i_wrap   (r_periodic),
        .i_coord  (w_rdata[COORD_BITS-1:0]),
        .i_sum    ('0),
        .i_tag    (w_tag0),
        .o_sum    (w_sum0),
        .o_tag    (w_tag1)
    );

    hsrp_cell u_cell_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_in_acc),
        .i_cand   (i_cand.data.cand_y),
        .i_period (r_period_y),
        .i_wrap   (r_periodic),
        .i_coord  (r_ydly[CELL_LAT-1]),
        .i_sum    (w_sum0),
        .i_tag    (w_tag1),
        .o_sum    (w_sum1),
        .o_tag    (w_tag)
    );

    hsrp_cell u_cell_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_in_acc),
        .i_cand   (i_cand.data.cand_z),
        .i_period ('0),
        .i_wrap   (1'b0),
        .i_coord  (r_zdly[2*CELL_LAT-1]),
        .i_sum    (w_sum1),
        .i_tag    (w_tag),
        .o_sum    (w_sum2),
        .o_tag    (w_tag2)
    );

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
endmodule

`default_nettype wire

FILE: rtl/core/hsrp_ram.sv
// ----------------------------------------------------------------------------
// hsrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

FILE: rtl/core/hsrp_cell.sv
// ----------------------------------------------------------------------------
// hsrp_cell
// One axis of the distance chain: wrapped |d|, square, add to running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsrp_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [hsrp_pkg::COORD_BITS-1:0]   i_cand,
    input  logic [hsrp_pkg::PER_W-1:0]        i_period,
    input  logic                              i_wrap,
    input  logic [hsrp_pkg::COORD_BITS-1:0]   i_coord,
    input  logic [hsrp_pkg::DIST_W-1:0]       i_sum,
    input  hsrp_pkg::t_tag                    i_tag,
    output logic [hsrp_pkg::DIST_W-1:0]       o_sum,
    output hsrp_pkg::t_tag                    o_tag
);
    import hsrp_pkg::*;

    logic [COORD_BITS-1:0] r_cand;
    logic [PER_W-1:0]      r_period;
    logic                  r_wrap;

    logic [COORD_BITS-1:0] w_abs;
    logic [PER_W-1:0]      w_ext;
    logic [PER_W-1:0]      w_alt;
    logic [COORD_BITS-1:0] n_d;

    logic [COORD_BITS-1:0] r_d;
    logic [DIST_W-1:0]     r_sum1;
    t_tag                  r_tag1;
    logic [SQ_W-1:0]       r_sq;
    logic [DIST_W-1:0]     r_sum2;
    t_tag                  r_tag2;
    logic [DIST_W-1:0]     r_sum3;
    t_tag                  r_tag3;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cand   <= i_cand;
            r_period <= i_period;
            r_wrap   <= i_wrap;
        end
    end

    always_comb begin
        w_abs = (i_coord >= r_cand) ? (i_coord - r_cand) : (r_cand - i_coord);
        w_ext = {1'b0, w_abs};
        w_alt = (r_period >= w_ext) ? (r_period - w_ext) : (w_ext - r_period);
        if (r_wrap && (w_alt < w_ext)) begin
            n_d = w_alt[COORD_BITS-1:0];
        end else begin
            n_d = w_abs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_sum1 <= i_sum;
        r_sq   <= SQ_W'(r_d) * SQ_W'(r_d);
        r_sum2 <= r_sum1;
        r_sum3 <= r_sum2 + DIST_W'(r_sq);
        r_tag1.last <= i_tag.last;
        r_tag1.idx  <= i_tag.idx;
        r_tag2.last <= r_tag1.last;
        r_tag2.idx  <= r_tag1.idx;
        r_tag3.last <= r_tag2.last;
        r_tag3.idx  <= r_tag2.idx;
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else begin
            r_tag1.valid <= i_tag.valid;
            r_tag2.valid <= r_tag1.valid;
            r_tag3.valid <= r_tag2.valid;
        end
    end

    assign o_sum = r_sum3;
    assign o_tag = r_tag3;
endmodule

`default_nettype wire

FILE: rtl/core/hsrp_chk.sv
// ----------------------------------------------------------------------------
// hsrp_chk
// Port-level checks on the placer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsrp_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  hsrp_pkg::t_res  i_out_data
);
    import hsrp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result request dropped or changed while stalled");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.status == ST_ACCEPT) ||
                        (i_out_data.status == ST_REJECT) ||
                        (i_out_data.status == ST_FULL))
        else $error("illegal status code");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != ST_ACCEPT) |-> i_out_data.point_index == '0)
        else $error("point index set on a non-accepted candidate");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared in the cycle after the candidate");
endmodule

bind hard_sphere_rejection_placer_unit hsrp_chk u_hsrp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cand.valid),
    .i_in_ready  (i_cand.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire
